/* sv/substring_match_scanner_unit_macros.svh */
// assertion macros for the substring match scanner checker
// no dependencies; included by the checker file
`ifndef SUBSTRING_MATCH_SCANNER_UNIT_MACROS_SVH
`define SUBSTRING_MATCH_SCANNER_UNIT_MACROS_SVH

// property checked only outside reset
`define SMSS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define SMSS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/smss_pkg.sv */
// shared types, constants and the case folding function of the substring match scanner
// no dependencies
package smss_pkg;

    localparam int PATTERN_MAX   = 128;
    localparam int POSITION_BITS = 16;
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
    localparam int START_W       = 16;
    localparam int SUM_W         = ((POSITION_BITS > START_W) ? POSITION_BITS : START_W) + 1;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } cmd_t;

    // control broadcast along the cell row
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       text;
        logic       exact;
        logic [7:0] data;
        logic [7:0] text_cmp;
    } smss_ctl_t;

    // lower case folding for the ansi code page
    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'h20;
        else if (c >= 8'hC0 && c <= 8'hDE && c != 8'hD7)
            r = c + 8'h20;
        else if (c == 8'h8A || c == 8'h8C || c == 8'h8E)
            r = c + 8'h10;
        else if (c == 8'h9F)
            r = 8'hFF;
        return r;
    endfunction

endpackage

/* sv/smss_cell.sv */
// one cell of the shift-and row: a pattern byte, an active flag and a prefix bit
// depends on smss_pkg
module smss_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  smss_pkg::smss_ctl_t ctl,
    input  logic               prev_bit,
    input  logic               prev_active,
    input  logic               next_active,
    output logic               bit_q,
    output logic               active_q,
    output logic               hit
);
    import smss_pkg::*;

    logic [7:0] byte_reg;
    logic       active_reg;
    logic       active_next;
    logic       bit_reg;
    logic       bit_next;
    logic       sel;
    logic       eq;
    logic [7:0] pat_cmp;

    // the first inactive cell takes the next appended byte
    assign sel     = prev_active && !active_reg;
    assign pat_cmp = ctl.exact ? byte_reg : fold_lower(byte_reg);
    assign eq      = (pat_cmp == ctl.text_cmp);

    always_comb
    begin
        active_next = active_reg;
        bit_next    = bit_reg;
        if (ctl.clear)
        begin
            active_next = 1'b0;
            bit_next    = 1'b0;
        end
        else if (ctl.append && sel)
        begin
            active_next = 1'b1;
        end
        else if (ctl.text && active_reg)
        begin
            bit_next = prev_bit && eq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bit_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append && sel)
            byte_reg <= ctl.data;
    end

    // last active cell reports a full match
    assign hit      = ctl.text && active_reg && !next_active && bit_next;
    assign bit_q    = bit_reg;
    assign active_q = active_reg;

endmodule

/* sv/substring_match_scanner_unit.sv */
// substring match scanner: command decode, position counter, cell row and output register
// depends on smss_pkg and smss_cell
//
// usage
//   input stream: s_tuser carries the command (clear, append pattern byte, text byte),
//   s_tdata the byte. every accepted input transfer yields exactly one result transfer.
//   result stream: m_tdata holds the match start position, m_tuser the match flag and
//   the pattern-full flag. match start is zero unless a match is flagged.
//   cfg channel: one write sets case_sensitive (1 exact, 0 fold to lower case);
//   cfg_ready is always high, write only while no result is pending.
//   timing: the result is registered and appears in the cycle after the input transfer.
//   throughput: one item per cycle while the result stream is not stalled; every cell of the row
//   compares its pattern byte with the text byte in the accept cycle and shifts its prefix bit to its neighbor.
//   stall: s_tready is high while the output register is empty or is being taken, so
//   a stalled receiver holds the result and the input waits, nothing is lost.
//   reset: pattern length, prefix bits, position and mode clear at once; no clearing
//   pass, pattern bytes are only read once written.
module substring_match_scanner_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [smss_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic [smss_pkg::IN_TUSER_W-1:0]      s_tuser,   // [1:0] command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [smss_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [15:0] match_start
    output logic [smss_pkg::OUT_TUSER_W-1:0]     m_tuser,   // [0] match_found, [1] pattern_full
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);
    import smss_pkg::*;

    logic                      exact_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          len_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;

    logic                      out_valid_reg;
    logic                      found_reg;
    logic                      found_next;
    logic                      full_reg;
    logic                      full_next;
    logic [START_W-1:0]        start_reg;
    logic [START_W-1:0]        start_next;

    logic                      accept;
    logic                      full;
    smss_ctl_t                 ctl;
    logic [SUM_W-1:0]          pos_plus;
    logic [SUM_W-1:0]          start_wide;
    logic                      match;

    logic [PATTERN_MAX-1:0]    bit_w;
    logic [PATTERN_MAX-1:0]    active_w;
    logic [PATTERN_MAX-1:0]    hit_w;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign full      = (len_reg == LEN_W'(PATTERN_MAX));

    always_comb
    begin
        ctl          = '0;
        ctl.exact    = exact_reg;
        ctl.data     = s_tdata;
        ctl.text_cmp = exact_reg ? s_tdata : fold_lower(s_tdata);
        if (accept)
        begin
            unique case (s_tuser)
                CMD_CLEAR:  ctl.clear  = 1'b1;
                CMD_APPEND: ctl.append = !full;
                CMD_TEXT:   ctl.text   = 1'b1;
                default:    ctl.clear  = 1'b0;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            logic prev_bit;
            logic prev_active;
            logic next_active;
            if (gi == 0)
            begin : g_first
                assign prev_bit    = 1'b1;
                assign prev_active = 1'b1;
            end
            else
            begin : g_mid
                assign prev_bit    = bit_w[gi-1];
                assign prev_active = active_w[gi-1];
            end
            if (gi == PATTERN_MAX - 1)
            begin : g_last
                assign next_active = 1'b0;
            end
            else
            begin : g_inner
                assign next_active = active_w[gi+1];
            end
            smss_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .prev_bit    (prev_bit),
                .prev_active (prev_active),
                .next_active (next_active),
                .bit_q       (bit_w[gi]),
                .active_q    (active_w[gi]),
                .hit         (hit_w[gi])
            );
        end
    endgenerate

    assign match    = |hit_w;
    assign pos_plus = SUM_W'(pos_reg) + SUM_W'(1);

    always_comb
    begin
        if (pos_plus >= SUM_W'(len_reg))
            start_wide = pos_plus - SUM_W'(len_reg);
        else
            start_wide = '0;
    end

    always_comb
    begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        found_next = 1'b0;
        full_next  = 1'b0;
        start_next = '0;
        if (ctl.clear)
        begin
            len_next = '0;
            pos_next = '0;
        end
        else if (ctl.append)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (ctl.text)
        begin
            found_next = match;
            if (match)
                start_next = start_wide[START_W-1:0];
            if (pos_reg != {POSITION_BITS{1'b1}})
                pos_next = pos_reg + POSITION_BITS'(1);
        end
        // dropped append reports the full store
        if (accept && s_tuser == CMD_APPEND && full)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_reg     <= 1'b0;
            len_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                exact_reg <= cfg_data;
            len_reg <= len_next;
            pos_reg <= pos_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= found_next;
            full_reg  <= full_next;
            start_reg <= start_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = start_reg;
    assign m_tuser  = {full_reg, found_reg};

endmodule

/* sv/smss_checker.sv */
// port-level checker for the substring match scanner, bound to the top level
// depends on substring_match_scanner_unit_macros.svh and smss_pkg
`include "substring_match_scanner_unit_macros.svh"

module smss_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [smss_pkg::IN_TUSER_W-1:0]  s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [smss_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [smss_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import smss_pkg::*;

    `SMSS_ASSERT(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `SMSS_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input not ready with empty output")

    `SMSS_ASSERT(a_clear_result, s_tvalid && s_tready && s_tuser == CMD_CLEAR |=> m_tvalid && m_tuser == '0 && m_tdata == '0, "clear transfer gave a nonzero result")

    `SMSS_ASSERT(a_start_only_on_match, m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !(m_tuser[0] && m_tuser[1]), "start position without a match")

endmodule

bind substring_match_scanner_unit smss_checker u_smss_checker (.*);

/* bench/tb_substring_match_scanner_unit.sv */
// self-checking bench for substring_match_scanner_unit: clocked driver and monitor,
// a predictor of the shift-and matcher and a store of expected result transfers
// depends on smss_pkg and the scanner rtl
module tb_substring_match_scanner_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import smss_pkg::*;

    localparam logic [1:0] CMD_SPARE  = 2'd3;   // unused command code, must be ignored
    localparam int         RAND_ITEMS = 1550;
    localparam int         MAX_REPORT = 200;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } scan_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] start;
        logic        full;
    } scan_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0] m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    scan_item_t   pending_q[$];
    scan_result_t expected_q[$];

    // predictor state
    logic                     exact_mode;
    logic [7:0]               pat_mem [PATTERN_MAX];
    int                       pat_len;
    logic [PATTERN_MAX-1:0]   prefix_hits;
    logic [POSITION_BITS-1:0] text_pos;

    // generator side copy of the pattern, used to build matching text
    logic [7:0] gen_pat[$];

    logic quiet = 1'b0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   err_count = 0;
    int   rand_items = 0;
    int   n_results = 0;
    int   n_matches = 0;
    int   n_drops = 0;

    substring_match_scanner_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tuser   (s_tuser),   // [1:0] command
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [15:0] match_start
        .m_tuser   (m_tuser),   // [0] match_found, [1] pattern_full
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] fold_lc(input logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDE && b != 8'hD7))
            return b + 8'h20;
        if (b == 8'h8A || b == 8'h8C || b == 8'h8E)
            return b + 8'h10;
        if (b == 8'h9F)
            return 8'hFF;
        return b;
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] b);
        logic [7:0] l;
        l = fold_lc(b);
        if (l != b)
            return l;
        if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'hE0 && b <= 8'hFE && b != 8'hF7))
            return b - 8'h20;
        if (b == 8'h9A || b == 8'h9C || b == 8'h9E)
            return b - 8'h10;
        if (b == 8'hFF)
            return 8'h9F;
        return b;
    endfunction

    function automatic int wait_draw();
        if (quiet)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    // one step of the shift-and row for an accepted input transfer
    function automatic scan_result_t match_step(input scan_item_t it);
        scan_result_t           r;
        logic [7:0]             t;
        logic [7:0]             p;
        logic [PATTERN_MAX-1:0] carry_in;
        logic [PATTERN_MAX-1:0] hits;
        longint                 first;
        r = '0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                prefix_hits = '0;
                text_pos = '0;
            end
            CMD_APPEND:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_mem[pat_len] = it.data;
                    pat_len++;
                end
                else
                    r.full = 1'b1;
            end
            CMD_TEXT:
            begin
                t = exact_mode ? it.data : fold_lc(it.data);
                carry_in = {prefix_hits[PATTERN_MAX-2:0], 1'b1};
                hits = prefix_hits;
                for (int k = 0; k < pat_len; k++)
                begin
                    p = exact_mode ? pat_mem[k] : fold_lc(pat_mem[k]);
                    hits[k] = carry_in[k] && (p == t);
                end
                prefix_hits = hits;
                if (pat_len > 0 && prefix_hits[pat_len-1])
                begin
                    first = longint'(text_pos) + 1 - pat_len;
                    r.found = 1'b1;
                    r.start = (first < 0) ? 16'd0 : first[15:0];
                end
                if (text_pos != '1)
                    text_pos++;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: presents the head of pending_q, predicts on each accepted transfer
    always @(posedge clk)
    begin
        logic present;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            exact_mode = 1'b0;
            pat_len = 0;
            prefix_hits = '0;
            text_pos = '0;
            send_gap = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                exact_mode = cfg_data;
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(match_step(pending_q.pop_front()));
                send_gap = wait_draw();
            end
            present = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_q.size() > 0)
                present = 1'b1;
            s_tvalid <= present;
            if (present)
            begin
                s_tuser <= pending_q[0].cmd;
                s_tdata <= pending_q[0].data;
            end
        end
    end

    // monitor: takes result transfers with random stalls and checks them
    always @(posedge clk)
    begin
        scan_result_t want;
        logic         rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    $error("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_q.pop_front();
                    n_results++;
                    if (want.found)
                        n_matches++;
                    if (want.full)
                        n_drops++;
                    // reports are capped so a broken run stays readable
                    if (m_tuser[0] !== want.found)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORT)
                            $error("match_found: expected %0d, got %0d", want.found, m_tuser[0]);
                    end
                    if (m_tdata !== want.start)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORT)
                            $error("match_start: expected %0d, got %0d", want.start, m_tdata);
                    end
                    if (m_tuser[1] !== want.full)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORT)
                            $error("pattern_full: expected %0d, got %0d", want.full, m_tuser[1]);
                    end
                end
                recv_stall = wait_draw();
            end
            rdy = 1'b1;
            if (recv_stall > 0)
            begin
                rdy = 1'b0;
                recv_stall--;
            end
            m_tready <= rdy;
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] data);
        scan_item_t it;
        it.cmd = cmd;
        it.data = data;
        pending_q.push_back(it);
        if (cmd != CMD_SPARE)
            rand_items++;
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic val);
        @(posedge clk);
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] set [14] = '{8'h61, 8'h62, 8'h41, 8'h42, 8'h7A, 8'h5A, 8'hC0,
                                 8'hE0, 8'h8A, 8'h9A, 8'h9F, 8'hFF, 8'hD7, 8'hF7};
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return set[$urandom_range(0, 13)];
    endfunction

    task automatic append_byte(input logic [7:0] b);
        push_item(CMD_APPEND, b);
        if (gen_pat.size() < PATTERN_MAX)
            gen_pat.push_back(b);
    endtask

    // a pattern and text built around copies of it, with noise, broken copies, extra appends and spare codes
    task automatic gen_sequence();
        int         plen;
        int         cut;
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0 || gen_pat.size() == 0)
        begin
            push_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
            gen_pat.delete();
        end
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 135) : $urandom_range(1, 6);
        repeat (plen)
            append_byte(pick_byte());
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // full or cut copy, case flips and rare corruption
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gen_pat.size())
                                                      : gen_pat.size();
                    for (int j = 0; j < cut; j++)
                    begin
                        b = gen_pat[j];
                        if ($urandom_range(0, 3) == 0)
                            b = swap_case(b);
                        if ($urandom_range(0, 49) == 0)
                            b = pick_byte();
                        push_item(CMD_TEXT, b);
                    end
                end
                4, 5, 6, 7:
                    repeat ($urandom_range(1, 5))
                        push_item(CMD_TEXT, pick_byte());
                8:
                    append_byte(pick_byte());
                default:
                    push_item(CMD_SPARE, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("tb_substring_match_scanner_unit: errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // folding: empty pattern, ignored code, accented and special pairs
        push_item(CMD_TEXT, 8'h61);
        push_item(CMD_SPARE, 8'hFF);
        push_item(CMD_APPEND, 8'h41);
        push_item(CMD_APPEND, 8'hC0);
        push_item(CMD_APPEND, 8'h8A);
        push_item(CMD_TEXT, 8'h61);
        push_item(CMD_TEXT, 8'hE0);
        push_item(CMD_TEXT, 8'h9A);
        push_item(CMD_TEXT, 8'hD7);
        push_item(CMD_CLEAR, 8'h00);
        push_item(CMD_APPEND, 8'h9F);
        push_item(CMD_APPEND, 8'hD7);
        push_item(CMD_TEXT, 8'hFF);
        push_item(CMD_TEXT, 8'hF7);
        push_item(CMD_TEXT, 8'h9F);
        push_item(CMD_TEXT, 8'hD7);
        push_item(CMD_TEXT, 8'h00);
        push_item(CMD_TEXT, 8'h5B);
        push_item(CMD_TEXT, 8'hDF);
        push_item(CMD_CLEAR, 8'hFF);
        wait_idle();
        write_mode(1'b1);
        push_item(CMD_APPEND, 8'h71);
        push_item(CMD_TEXT, 8'h51);
        push_item(CMD_TEXT, 8'h71);
        wait_idle();

        // fill the pattern store, overflow it, then match the full length
        write_mode(1'b0);
        push_item(CMD_CLEAR, 8'h00);
        repeat (PATTERN_MAX)
            push_item(CMD_APPEND, $urandom_range(0, 1) ? 8'h78 : 8'h58);
        repeat (3)
            push_item(CMD_APPEND, 8'($urandom_range(0, 255)));
        repeat (PATTERN_MAX + 3)
            push_item(CMD_TEXT, $urandom_range(0, 1) ? 8'h78 : 8'h58);
        wait_idle();
        push_item(CMD_CLEAR, 8'h00);
        gen_pat.delete();
        wait_idle();

        rand_items = 0;
        write_mode(1'b1);
        while (rand_items < RAND_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4))
                gen_sequence();
            // sender holds off until every result is back, then mode may flip
            wait_idle();
            write_mode(1'($urandom_range(0, 1)));
        end
        wait_idle();
        repeat (4) @(posedge clk);

        $display("covered %0d results, %0d matches, %0d dropped pattern bytes,",
                 n_results, n_matches, n_drops);
        $display("both compare modes, a full pattern store and random stalls on both sides");
        if (err_count == 0)
            $display("tb_substring_match_scanner_unit: clean");
        else
            $display("tb_substring_match_scanner_unit: errors");
        $finish;
    end

endmodule
